FILE: rtl/smpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int DEPTH   = 16;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] val;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/smpq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_if
// Valid/ready channels for the queue's commands and results.
// ----------------------------------------------------------------------------
interface smpq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [smpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface smpq_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [smpq_pkg::VALUE_W-1:0] value_out;
  logic [smpq_pkg::COUNT_W-1:0]        count;
  logic                                empty_res;

  modport source (output valid, output status, output value_out, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input value_out, input count,
                  input empty_res, output ready);
endinterface
`default_nettype wire

FILE: rtl/smpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: holds a value, takes the new value, its left
// neighbour's value or its right neighbour's value.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  wire logic                                clk,
  input  wire smpq_pkg::cmd_t                      cmd,
  input  wire logic                                occ,
  input  wire logic                                left_gt,
  input  wire logic signed [smpq_pkg::VALUE_W-1:0] left_q,
  input  wire logic signed [smpq_pkg::VALUE_W-1:0] right_q,
  output logic                                     gt,
  output logic signed [smpq_pkg::VALUE_W-1:0]      q
);

  logic signed [smpq_pkg::VALUE_W-1:0] q_r;
  logic signed [smpq_pkg::VALUE_W-1:0] q_nxt;

  // Stored value lies strictly above the new one: it must move right.
  assign gt = occ && (q_r > cmd.val);
  assign q  = q_r;

  always_comb begin
    q_nxt = q_r;
    if (cmd.ins) begin
      if (left_gt) begin
        q_nxt = left_q;
      end else if (gt || !occ) begin
        q_nxt = cmd.val;
      end
    end else if (cmd.rem) begin
      q_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/sorted_min_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Sorted-list minimum priority queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH signed 32-bit values in ascending order in a row
// of cells, the smallest at cell 0. Each transfer on the input channel is an
// insert (mode 0) or a remove of the smallest value (mode 1) and produces
// exactly one result transfer carrying a status, the value, the count after
// the item and an empty flag. Every cell compares its value with the broadcast
// insert value in parallel, so a new item is taken in every cycle while the
// result register is free or being drained. Equal values leave in arrival
// order. Remove on an empty queue reports ST_EMPTY and insert on a full queue
// reports ST_FULL; both return zero and leave the contents untouched. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smpq_in_if.sink     in_chan,
  smpq_out_if.source  out_chan
);

  localparam int N  = smpq_pkg::DEPTH;
  localparam int FW = smpq_pkg::FILL_W;
  localparam int VW = smpq_pkg::VALUE_W;
  localparam int CW = smpq_pkg::COUNT_W;

  logic [FW-1:0]           fill_r;
  logic [FW-1:0]           fill_nxt;
  logic                    out_valid_r;
  smpq_pkg::status_t       status_r;
  smpq_pkg::status_t       status_nxt;
  logic signed [VW-1:0]    vout_r;
  logic signed [VW-1:0]    vout_nxt;

  logic                    xfer;
  logic                    is_remove;
  logic                    full;
  logic                    empty;
  smpq_pkg::cmd_t          cmd;

  logic                    gt   [N];
  logic signed [VW-1:0]    q    [N];

  // Take a new item whenever the result register is empty or draining.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign xfer          = in_chan.valid && in_chan.ready;
  assign is_remove     = (in_chan.mode == smpq_pkg::MODE_REMOVE);
  assign full          = (fill_r == FW'(N));
  assign empty         = (fill_r == '0);

  assign cmd.ins = xfer && !is_remove && !full;
  assign cmd.rem = xfer && is_remove && !empty;
  assign cmd.val = in_chan.value;

  // Row of cells: each looks at its left neighbour for inserts and its right
  // neighbour for removes. Cell 0 has no left neighbour; the last cell keeps
  // its own value on remove.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                 occ;
    logic                 lgt;
    logic signed [VW-1:0] lq;
    logic signed [VW-1:0] rq;

    assign occ = (fill_r > FW'(i));

    if (i == 0) begin : g_head
      assign lgt = 1'b0;
      assign lq  = q[i];
    end else begin : g_body
      assign lgt = gt[i-1];
      assign lq  = q[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rq = q[i];
    end else begin : g_inner
      assign rq = q[i+1];
    end

    smpq_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .occ     (occ),
      .left_gt (lgt),
      .left_q  (lq),
      .right_q (rq),
      .gt      (gt[i]),
      .q       (q[i])
    );
  end

  // Work out the result and the new fill for the item in flight.
  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = smpq_pkg::ST_OK;
    vout_nxt   = '0;
    if (is_remove) begin
      if (empty) begin
        status_nxt = smpq_pkg::ST_EMPTY;
      end else begin
        vout_nxt = q[0];
        fill_nxt = fill_r - FW'(1);
      end
    end else begin
      if (full) begin
        status_nxt = smpq_pkg::ST_FULL;
      end else begin
        vout_nxt = in_chan.value;
        fill_nxt = fill_r + FW'(1);
      end
    end
  end

  // Control: fill count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next transfer in.
  always_ff @(posedge clk) begin
    if (xfer) begin
      status_r <= status_nxt;
      vout_r   <= vout_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.value_out = vout_r;
  assign out_chan.count     = CW'(fill_r);
  assign out_chan.empty_res = (fill_r == '0);

endmodule
`default_nettype wire
